// ===== design/klock_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package klock_pkg;

  localparam int CodeDigits    = 5;
  localparam int MaxCodeDigits = 16;
  localparam int KeyW          = 4;
  localparam int StatusW       = 3;
  localparam int CountW        = 3;
  localparam int FailW         = 2;
  localparam int MasterW       = 20;
  localparam int MasterDigits  = MasterW / KeyW;
  localparam int InDataW       = 8;
  localparam int OutDataW      = 8;

  localparam logic [MasterW-1:0] MasterReset = 20'h56246;

  localparam logic [KeyW-1:0] ResetCode [MaxCodeDigits] = '{
    4'd2, 4'd5, 4'd6, 4'd3, 4'd8, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  localparam logic [StatusW-1:0] StDigit      = 3'd0;
  localparam logic [StatusW-1:0] StGranted    = 3'd1;
  localparam logic [StatusW-1:0] StRetry      = 3'd2;
  localparam logic [StatusW-1:0] StNeedMaster = 3'd3;
  localparam logic [StatusW-1:0] StMasterOk   = 3'd4;
  localparam logic [StatusW-1:0] StAlarm      = 3'd5;
  localparam logic [StatusW-1:0] StStored     = 3'd6;

  localparam logic [FailW-1:0] FailMax = 2'd2;

endpackage

`default_nettype wire

// ===== design/keypad_code_lock_top.sv =====
// A result is registered in the output register in the cycle after its key transfer.
// Throughput: one key per cycle while the output sink is ready; the digit compare and position update sit in one stage.
// A key is taken while a result waits, as long as that result leaves in the same cycle.
// Reset (asynchronous, active low) empties the output register, loads the stored code
// with its default digits and the master code with its default, and starts a check entry.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock_top #(
  parameter int CODE_DIGITS = klock_pkg::CodeDigits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [klock_pkg::MasterW-1:0]    cfg_data_i,      // master_code
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [klock_pkg::InDataW-1:0]    s_axis_tdata,    // key_value[3:0], change_request[4]
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [klock_pkg::OutDataW-1:0]   m_axis_tdata     // status[2:0], digits_entered[5:3], failures[7:6]
);
  import klock_pkg::*;

  localparam int PosW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(CODE_DIGITS - 1);

  typedef enum logic [1:0] {
    PH_CHECK  = 2'd0,
    PH_CHANGE = 2'd1,
    PH_MASTER = 2'd2
  } phase_e;

  logic [MasterW-1:0] master_q;
  logic [KeyW-1:0]    code_q [CODE_DIGITS];
  logic [PosW-1:0]    pos_q, pos_d;
  phase_e             phase_q, phase_d, phase_eff;
  logic               mis_q, mis_d, mis_now;
  logic [FailW-1:0]   fail_q, fail_d;
  logic               out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [CountW-1:0]  count_q;

  logic               in_xfer;
  logic [KeyW-1:0]    key;
  logic               req;
  logic               first;
  logic               last;
  logic [5:0]         master_sh;
  logic [KeyW-1:0]    master_dig;
  logic [KeyW-1:0]    stored_dig;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign key           = s_axis_tdata[KeyW-1:0];
  assign req           = s_axis_tdata[KeyW];
  assign first         = (pos_q == '0);
  assign last          = (pos_q == LastPos);
  assign master_sh     = 6'(KeyW * (CODE_DIGITS - 1 - int'(pos_q)));
  assign master_dig    = KeyW'(master_q >> master_sh);
  assign stored_dig    = code_q[pos_q];

  always_comb begin
    if (first && phase_q != PH_MASTER) begin
      phase_eff = req ? PH_CHANGE : PH_CHECK;
    end else begin
      phase_eff = phase_q;
    end
  end

  always_comb begin
    mis_now  = first ? 1'b0 : mis_q;
    pos_d    = pos_q + PosW'(1);
    phase_d  = phase_eff;
    fail_d   = fail_q;
    status_d = StDigit;
    unique case (phase_eff)
      PH_MASTER: mis_now = mis_now || (key != master_dig);
      PH_CHANGE: mis_now = mis_now;
      default:   mis_now = mis_now || (key != stored_dig);
    endcase
    mis_d = mis_now;
    if (last) begin
      pos_d   = '0;
      mis_d   = 1'b0;
      phase_d = PH_CHECK;
      unique case (phase_eff)
        PH_CHANGE: status_d = StStored;
        PH_MASTER: begin
          fail_d   = '0;
          status_d = mis_now ? StAlarm : StMasterOk;
        end
        default: begin
          if (!mis_now) begin
            fail_d   = '0;
            status_d = StGranted;
          end else if (fail_q < FailMax) begin
            fail_d   = fail_q + FailW'(1);
            status_d = StRetry;
          end else begin
            fail_d   = FailMax;
            status_d = StNeedMaster;
            phase_d  = PH_MASTER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q    <= MasterReset;
      pos_q       <= '0;
      phase_q     <= PH_CHECK;
      mis_q       <= 1'b0;
      fail_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        code_q[i] <= ResetCode[i];
      end
    end else begin
      if (cfg_valid_i) begin
        master_q <= cfg_data_i;
      end
      if (in_xfer) begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        mis_q   <= mis_d;
        fail_q  <= fail_d;
        if (phase_eff == PH_CHANGE) begin
          code_q[pos_q] <= key;
        end
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_q <= status_d;
      count_q  <= CountW'(pos_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {fail_q, count_q, status_q};

  // hold position inside one entry
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pos_q) < CODE_DIGITS)
    else $error("digit position out of range");

  a_master_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_MASTER |-> fail_q == FailMax)
    else $error("master entry pending without full failure count");

  a_need_master: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last && status_d == StNeedMaster |=> phase_q == PH_MASTER && pos_q == '0)
    else $error("master entry not armed after third failure");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != StDigit |-> count_q == '0)
    else $error("completed entry reports digits");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("result register not loaded after transfer");

endmodule

`default_nettype wire

// ===== tb/keypad_code_lock_top_tb.sv =====
`timescale 1ns / 1ps

module keypad_code_lock_top_tb;
  import klock_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef enum logic [1:0] {PhCheck, PhChange, PhMaster} lock_phase_e;

  // Packed to match m_axis_tdata bit for bit
  typedef struct packed {
    logic [FailW-1:0]   fails;
    logic [CountW-1:0]  digits;
    logic [StatusW-1:0] status;
  } lock_res_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            req;
  } key_item_t;

  typedef struct {
    logic [KeyW-1:0] key;
    logic            req;
    bit              typed;
    lock_res_t       res;
  } key_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [MasterW-1:0]  cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predicted lock state
  logic [KeyW-1:0]    code_mem [MaxCodeDigits];
  logic [MasterW-1:0] master_reg;
  int unsigned        dig_pos;
  lock_phase_e        phase;
  bit                 miss;
  logic [FailW-1:0]   fail_cnt;

  lock_res_t   awaited_res_q [$];
  key_item_t   key_plan [$];
  key_row_t    dir_rows [30];
  int unsigned errors;
  int unsigned keys_sent;
  int unsigned results_seen;
  int unsigned status_hits [8];
  int unsigned cycle_cnt;
  int unsigned burst_left = 4;
  int unsigned gap_max;
  bit          long_hold_done;

  always #1 clk_i = ~clk_i;

  keypad_code_lock_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [KeyW-1:0] master_nib(input int unsigned p);
    return master_reg[KeyW*(CodeDigits-1-p) +: KeyW];
  endfunction

  task automatic lock_reset();
    foreach (code_mem[i]) code_mem[i] = ResetCode[i];
    master_reg = MasterReset;
    dig_pos    = 0;
    phase      = PhCheck;
    miss       = 1'b0;
    fail_cnt   = '0;
  endtask

  task automatic predict_lock(input logic [KeyW-1:0] key, input logic req,
                              output lock_res_t res);
    int unsigned p;
    p = dig_pos;
    res.status = StDigit;
    if (p >= CodeDigits) p = 0;
    if (p == 0) begin
      if (phase != PhMaster) phase = req ? PhChange : PhCheck;
      miss = 1'b0;
    end
    case (phase)
      PhChange: code_mem[p] = key;
      PhMaster: miss = miss || (key != master_nib(p));
      default:  miss = miss || (key != code_mem[p]);
    endcase
    p++;
    if (p >= CodeDigits) begin
      p = 0;
      if (phase == PhChange) begin
        res.status = StStored;
        phase      = PhCheck;
      end else if (phase == PhMaster) begin
        fail_cnt   = '0;
        res.status = miss ? StAlarm : StMasterOk;
        phase      = PhCheck;
      end else if (!miss) begin
        fail_cnt   = '0;
        res.status = StGranted;
        phase      = PhCheck;
      end else if (fail_cnt < FailMax) begin
        fail_cnt++;
        res.status = StRetry;
        phase      = PhCheck;
      end else begin
        fail_cnt   = FailMax;
        res.status = StNeedMaster;
        phase      = PhMaster;
      end
      miss = 1'b0;
    end
    dig_pos    = p;
    res.digits = CountW'(p);
    res.fails  = fail_cnt;
  endtask

  // Plan the rest of the current entry from the predicted state, or a short run of random keys
  task automatic plan_entry();
    int unsigned first, r, n, flip;
    key_item_t   it;
    first = dig_pos;
    r     = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        it.key = KeyW'($urandom_range(0, 15));
        it.req = 1'($urandom_range(0, 1));
        key_plan.push_back(it);
      end
    end else begin
      flip = (r < 22) ? $urandom_range(first, CodeDigits - 1) : CodeDigits;
      for (int p = first; p < CodeDigits; p++) begin
        it.key = KeyW'($urandom_range(0, 15));
        it.req = 1'($urandom_range(0, 1));
        if (phase == PhMaster) begin
          if (r < 70) it.key = master_nib(p);
        end else if (r < 55) begin
          it.key = code_mem[p];
          if (p == 0) it.req = 1'b0;
        end else if (r < 75) begin
          if (p == 0) it.req = 1'b0;
        end else if (p == 0) begin
          it.req = 1'b1;
        end
        if (p == flip) it.key = it.key ^ KeyW'($urandom_range(1, 15));
        key_plan.push_back(it);
      end
    end
  endtask

  task automatic send_key(input logic [KeyW-1:0] key, input logic req, input bit typed,
                          input lock_res_t tres);
    lock_res_t   pred;
    int unsigned g;
    s_axis_tdata  <= {3'b000, req, key};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_lock(key, req, pred);
    awaited_res_q.push_back(typed ? tres : pred);
    keys_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      g          = $urandom_range(0, gap_max);
      if (g > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_keys();
    s_axis_tvalid <= 1'b0;
    while (awaited_res_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_master(input logic [MasterW-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    master_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned gmax);
    key_item_t   it;
    int unsigned sent;
    gap_max = gmax;
    sent    = 0;
    while (sent < n_items) begin
      if (key_plan.size() == 0) plan_entry();
      it = key_plan.pop_front();
      send_key(it.key, it.req, 1'b0, '0);
      sent++;
    end
    key_plan.delete();
    drain_keys();
  endtask

  initial begin : main_seq
    dir_rows = '{
      '{4'd2,  1'b0, 1'b1, {2'd0, 3'd1, StDigit}},
      '{4'd5,  1'b0, 1'b1, {2'd0, 3'd2, StDigit}},
      '{4'd6,  1'b1, 1'b1, {2'd0, 3'd3, StDigit}},
      '{4'd3,  1'b0, 1'b1, {2'd0, 3'd4, StDigit}},
      '{4'd8,  1'b0, 1'b1, {2'd0, 3'd0, StGranted}},
      '{4'd15, 1'b0, 1'b0, '0},
      '{4'd0,  1'b0, 1'b0, '0},
      '{4'd10, 1'b1, 1'b0, '0},
      '{4'd0,  1'b0, 1'b0, '0},
      '{4'd15, 1'b0, 1'b1, {2'd1, 3'd0, StRetry}},
      '{4'd0,  1'b0, 1'b0, '0},
      '{4'd0,  1'b0, 1'b0, '0},
      '{4'd0,  1'b0, 1'b0, '0},
      '{4'd0,  1'b0, 1'b0, '0},
      '{4'd0,  1'b0, 1'b1, {2'd2, 3'd0, StRetry}},
      '{4'd10, 1'b0, 1'b0, '0},
      '{4'd10, 1'b0, 1'b0, '0},
      '{4'd10, 1'b0, 1'b0, '0},
      '{4'd10, 1'b0, 1'b0, '0},
      '{4'd10, 1'b0, 1'b1, {2'd2, 3'd0, StNeedMaster}},
      '{4'd5,  1'b1, 1'b0, '0},
      '{4'd6,  1'b0, 1'b0, '0},
      '{4'd2,  1'b1, 1'b0, '0},
      '{4'd4,  1'b0, 1'b0, '0},
      '{4'd7,  1'b0, 1'b1, {2'd0, 3'd0, StAlarm}},
      '{4'd15, 1'b1, 1'b0, '0},
      '{4'd0,  1'b0, 1'b0, '0},
      '{4'd10, 1'b0, 1'b0, '0},
      '{4'd9,  1'b1, 1'b0, '0},
      '{4'd1,  1'b0, 1'b1, {2'd0, 3'd0, StStored}}
    };
    lock_reset();
    gap_max = 3;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_key(dir_rows[i].key, dir_rows[i].req, dir_rows[i].typed,
                                   dir_rows[i].res);
    drain_keys();
    run_random(140, 4);
    write_master(20'hFFFFF);
    run_random(140, 0);
    write_master(20'h00000);
    run_random(140, 8);
    write_master(MasterW'($urandom()));
    run_random(130, 2);
    repeat (4) @(posedge clk_i);
    $display("Covered %0d key transfers under four master-code settings, with sender gaps,",
             keys_sent);
    $display("sink stalls and one long hold; granted %0d retry %0d master-needed %0d master-ok %0d alarm %0d stored %0d",
             status_hits[StGranted], status_hits[StRetry], status_hits[StNeedMaster],
             status_hits[StMasterOk], status_hits[StAlarm], status_hits[StStored]);
    if (errors == 0 && awaited_res_q.size() == 0) begin
      $display("keypad_code_lock_top verification clean");
    end else begin
      $display("keypad_code_lock_top verification failed");
    end
    $finish;
  end

  initial begin : sink_pattern
    int unsigned kind, seg;
    forever begin
      kind = $urandom_range(0, 3);
      seg  = $urandom_range(10, 60);
      for (int i = 0; i < seg; i++) begin
        @(posedge clk_i);
        if (!long_hold_done && results_seen >= 120) begin
          m_axis_tready <= 1'b0;
          repeat (300) @(posedge clk_i);
          long_hold_done = 1'b1;
        end else begin
          case (kind)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (i % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin : res_check
    lock_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      status_hits[got.status]++;
      if (awaited_res_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing awaited, got %h", $time, got);
      end else begin
        want = awaited_res_q.pop_front();
        if (got.status != want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (got.digits != want.digits) begin
          errors++;
          $display("%0t: digits_entered expected %0d got %0d", $time, want.digits,
                   got.digits);
        end
        if (got.fails != want.fails) begin
          errors++;
          $display("%0t: failures expected %0d got %0d", $time, want.fails, got.fails);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: run stopped after %0d cycles, %0d results still awaited", $time,
               cycle_cnt, awaited_res_q.size());
      $display("keypad_code_lock_top verification failed");
      $finish;
    end
  end

endmodule
